FILE: sv/erma_pkg.sv
// ----------------------------------------------------------------------------
// erma_pkg
// Shared widths, constants, register indexes and the controller state type
// for the echo range moving average block.
// ----------------------------------------------------------------------------
package erma_pkg;

	localparam int ECHO_W      = 15;
	localparam int DIST_W      = 16;
	localparam int FACTOR_W    = 11;
	localparam int PROD_W      = ECHO_W + FACTOR_W;
	localparam int DIST_SHIFT  = 8;
	localparam int FULL_DIST_W = PROD_W - DIST_SHIFT;

	localparam logic [ECHO_W-1:0]   ECHO_TIMEOUT_US = ECHO_W'(30000);
	localparam logic [FACTOR_W-1:0] CM_PER_US_Q16   = FACTOR_W'(1124);

	localparam logic [DIST_W-1:0] MAX_RANGE_RESET  = DIST_W'(10240);
	localparam logic [DIST_W-1:0] NEAR_LIMIT_RESET = DIST_W'(5120);

	localparam int WINDOW_DEPTH_DEFAULT = 5;

	// Quotient bits resolved per cycle by the divider.
	localparam int DIV_BITS_PER_CYCLE = 4;

	// Configuration port.
	localparam int APB_DATA_W = 32;
	localparam int APB_ADDR_W = 3;
	localparam logic REG_MAX_RANGE  = 1'b0;
	localparam logic REG_NEAR_LIMIT = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SUM,
		ST_DIV,
		ST_EMIT
	} state_t;

endpackage

FILE: sv/erma_cell.sv
// ----------------------------------------------------------------------------
// erma_cell
// One window entry. Loads the word offered by its neighbour when enabled.
// ----------------------------------------------------------------------------
module erma_cell (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          load,
	input  logic [erma_pkg::DIST_W-1:0]   d,
	output logic [erma_pkg::DIST_W-1:0]   q
);

	logic [erma_pkg::DIST_W-1:0] value_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			value_q <= '0;
		end else if (load) begin
			value_q <= d;
		end
	end

	assign q = value_q;

endmodule

FILE: sv/erma_divider.sv
// ----------------------------------------------------------------------------
// erma_divider
// Iterative restoring divider, DIV_BITS_PER_CYCLE quotient bits per cycle.
// ----------------------------------------------------------------------------
module erma_divider #(
	parameter int DIVIDEND_W = 19,
	parameter int DIVISOR_W  = 3
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [DIVIDEND_W-1:0]  dividend,
	input  logic [DIVISOR_W-1:0]   divisor,
	output logic                   done,
	output logic [DIVIDEND_W-1:0]  quotient
);

	localparam int R       = erma_pkg::DIV_BITS_PER_CYCLE;
	localparam int DIV_CYC = (DIVIDEND_W + R - 1) / R;
	localparam int DIV_W   = DIV_CYC * R;
	localparam int CNT_W   = $clog2(DIV_CYC + 1);

	logic [DIVISOR_W-1:0] rem_q;
	logic [DIV_W-1:0]     quo_q;
	logic [DIVISOR_W-1:0] div_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 busy_q;
	logic                 done_q;

	logic [DIVISOR_W-1:0] rem_next;
	logic [DIV_W-1:0]     quo_next;

	// R dependent compare and subtract steps on narrow values.
	always_comb begin
		logic [DIVISOR_W:0] trial;
		rem_next = rem_q;
		quo_next = quo_q;
		for (int i = 0; i < R; i++) begin
			trial = {rem_next, quo_next[DIV_W-1]};
			if (trial >= {1'b0, div_q}) begin
				trial    = trial - {1'b0, div_q};
				quo_next = {quo_next[DIV_W-2:0], 1'b1};
			end else begin
				quo_next = {quo_next[DIV_W-2:0], 1'b0};
			end
			rem_next = trial[DIVISOR_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !start && busy_q && (cnt_q == CNT_W'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DIV_CYC);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= DIV_W'(dividend);
			div_q <= divisor;
		end else if (busy_q) begin
			rem_q <= rem_next;
			quo_q <= quo_next;
		end
	end

	assign done     = done_q;
	assign quotient = quo_q[DIVIDEND_W-1:0];

endmodule

FILE: sv/echo_range_moving_average.sv
// ----------------------------------------------------------------------------
// echo_range_moving_average
// Converts echo pulse widths to distances and reports a moving average
// with a near indicator.
// ----------------------------------------------------------------------------
// Each input word on in_valid/in_stall carries one echo pulse width in
// microseconds, zero meaning a timeout. Each accepted word gives exactly one
// result word on out_valid/out_stall: reading_valid, avg_distance_q8,
// near_on and report. The user must write the two thresholds over APB only
// while the block is idle; the block does not enforce this. Register 0
// (address 0) is max_range_q8 and register 1 (address 4) is near_limit_q8.
// A word is held in a row of WINDOW_DEPTH cells. A valid reading is shifted
// into the row, then the row rotates once round, one cell per cycle, while
// the tail cell is added into an accumulator. The sum then goes to an
// iterative divider that resolves four quotient bits per cycle.
// After acceptance a valid reading passes through the sum, divide and emit
// states before the next word is taken. A timed-out or out-of-range reading
// skips the window and goes straight from the idle state to the emit state.
// The result sits in an output register, so the next word is accepted while
// a stalled result waits; a finished result waits in turn until the output
// register is free. Reset empties the window, clears the fill count and
// restores both thresholds to their default values.
// ----------------------------------------------------------------------------
module echo_range_moving_average #(
	parameter int WINDOW_DEPTH = erma_pkg::WINDOW_DEPTH_DEFAULT
) (
	input  logic                              clk,
	input  logic                              arst_n,

	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [erma_pkg::APB_ADDR_W-1:0]   paddr,
	input  logic [erma_pkg::APB_DATA_W-1:0]   pwdata,
	output logic [erma_pkg::APB_DATA_W-1:0]   prdata,
	output logic                              pready,

	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [erma_pkg::ECHO_W-1:0]       echo_us,

	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              reading_valid,
	output logic [erma_pkg::DIST_W-1:0]       avg_distance_q8,
	output logic                              near_on,
	output logic                              report
);

	localparam int DW    = erma_pkg::DIST_W;
	localparam int SUM_W = DW + $clog2(WINDOW_DEPTH);
	localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
	localparam int ROT_W = $clog2(WINDOW_DEPTH + 1);

	// Configuration registers. Only bit 2 of the address selects a register.
	logic [DW-1:0] max_range_q;
	logic [DW-1:0] near_limit_q;
	logic          cfg_write;

	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_range_q  <= erma_pkg::MAX_RANGE_RESET;
			near_limit_q <= erma_pkg::NEAR_LIMIT_RESET;
		end else if (cfg_write) begin
			if (paddr[2] == erma_pkg::REG_MAX_RANGE) begin
				max_range_q <= pwdata[DW-1:0];
			end else begin
				near_limit_q <= pwdata[DW-1:0];
			end
		end
	end

	always_comb begin
		if (paddr[2] == erma_pkg::REG_NEAR_LIMIT) begin
			prdata = erma_pkg::APB_DATA_W'(near_limit_q);
		end else begin
			prdata = erma_pkg::APB_DATA_W'(max_range_q);
		end
	end

	// Distance in centimetres Q8: width times 1124, shifted right by eight.
	logic [erma_pkg::PROD_W-1:0]      prod;
	logic [erma_pkg::FULL_DIST_W-1:0] dist_full;
	logic                             echo_ok;

	assign prod      = erma_pkg::PROD_W'(echo_us) * erma_pkg::PROD_W'(erma_pkg::CM_PER_US_Q16);
	assign dist_full = prod[erma_pkg::PROD_W-1:erma_pkg::DIST_SHIFT];
	assign echo_ok   = (echo_us != '0) && (echo_us <= erma_pkg::ECHO_TIMEOUT_US)
		&& (dist_full <= erma_pkg::FULL_DIST_W'(max_range_q));

	// Controller.
	erma_pkg::state_t state_q, state_next;
	logic             accept;
	logic             shift_en;
	logic             rot_en;
	logic             div_start;
	logic             emit;
	logic             out_free;
	logic             div_done;
	logic [ROT_W-1:0] rot_q;
	logic             rot_last;

	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid || !out_stall;
	assign rot_last = (rot_q == ROT_W'(WINDOW_DEPTH - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= erma_pkg::ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		in_stall   = 1'b1;
		shift_en   = 1'b0;
		rot_en     = 1'b0;
		div_start  = 1'b0;
		emit       = 1'b0;
		case (state_q)
			erma_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					shift_en   = echo_ok;
					state_next = echo_ok ? erma_pkg::ST_SUM : erma_pkg::ST_EMIT;
				end
			end
			erma_pkg::ST_SUM: begin
				rot_en = 1'b1;
				if (rot_last) begin
					div_start  = 1'b1;
					state_next = erma_pkg::ST_DIV;
				end
			end
			erma_pkg::ST_DIV: begin
				if (div_done) begin
					state_next = erma_pkg::ST_EMIT;
				end
			end
			erma_pkg::ST_EMIT: begin
				if (out_free) begin
					emit       = 1'b1;
					state_next = erma_pkg::ST_IDLE;
				end
			end
			default: begin
				state_next = erma_pkg::ST_IDLE;
			end
		endcase
	end

	// Row of window cells. A new reading enters cell 0 and the oldest drops
	// off the tail; while summing the tail wraps round to cell 0 instead.
	logic [DW-1:0] cell_q [WINDOW_DEPTH];
	logic [DW-1:0] cell_d [WINDOW_DEPTH];
	logic          cell_load;
	logic [DW-1:0] tail;

	assign cell_load = shift_en || rot_en;
	assign tail      = cell_q[WINDOW_DEPTH-1];

	for (genvar k = 0; k < WINDOW_DEPTH; k++) begin : g_cell
		if (k == 0) begin : g_head
			assign cell_d[k] = rot_en ? tail : dist_full[DW-1:0];
		end else begin : g_body
			assign cell_d[k] = cell_q[k-1];
		end
		erma_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.load   (cell_load),
			.d      (cell_d[k]),
			.q      (cell_q[k])
		);
	end

	// Fill count, rotation counter and accumulator.
	logic [CNT_W-1:0] fill_q;
	logic [SUM_W-1:0] acc_q;
	logic [SUM_W-1:0] acc_next;

	assign acc_next = acc_q + SUM_W'(tail);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			rot_q  <= '0;
		end else begin
			if (shift_en) begin
				rot_q <= '0;
				if (fill_q != CNT_W'(WINDOW_DEPTH)) begin
					fill_q <= fill_q + CNT_W'(1);
				end
			end else if (rot_en) begin
				rot_q <= rot_q + ROT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (shift_en) begin
			acc_q <= '0;
		end else if (rot_en) begin
			acc_q <= acc_next;
		end
	end

	// Mean: sum over the row divided by the fill count. Unfilled cells are
	// still zero, so summing the whole row is the same as summing the
	// entries written so far.
	logic [SUM_W-1:0] quotient;

	erma_divider #(
		.DIVIDEND_W (SUM_W),
		.DIVISOR_W  (CNT_W)
	) u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (acc_next),
		.divisor  (fill_q),
		.done     (div_done),
		.quotient (quotient)
	);

	// Pending result, waiting for the output register.
	logic          res_valid_q;
	logic [DW-1:0] res_avg_q;

	always_ff @(posedge clk) begin
		if (accept && !echo_ok) begin
			res_valid_q <= 1'b0;
			res_avg_q   <= '0;
		end else if (state_q == erma_pkg::ST_DIV && div_done) begin
			res_valid_q <= 1'b1;
			res_avg_q   <= quotient[DW-1:0];
		end
	end

	// Near indicator and report flag are settled as the word is handed out.
	logic res_near;
	logic last_near_q;
	logic first_pending_q;

	assign res_near = res_valid_q && (res_avg_q < near_limit_q);

	logic          out_valid_q;
	logic          out_reading_q;
	logic [DW-1:0] out_avg_q;
	logic          out_near_q;
	logic          out_report_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q     <= 1'b0;
			last_near_q     <= 1'b0;
			first_pending_q <= 1'b1;
		end else begin
			if (emit) begin
				out_valid_q     <= 1'b1;
				last_near_q     <= res_near;
				first_pending_q <= 1'b0;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_reading_q <= res_valid_q;
			out_avg_q     <= res_avg_q;
			out_near_q    <= res_near;
			out_report_q  <= first_pending_q || (res_near != last_near_q);
		end
	end

	assign out_valid       = out_valid_q;
	assign reading_valid   = out_reading_q;
	assign avg_distance_q8 = out_avg_q;
	assign near_on         = out_near_q;
	assign report          = out_report_q;

	// Checks on the controller and datapath.
	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == erma_pkg::ST_DIV)
		else $error("divider finished outside the divide state");

	a_fill_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_W'(WINDOW_DEPTH))
		else $error("fill count beyond window depth");

	a_near_needs_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (!near_on || reading_valid))
		else $error("near indicator set on an invalid reading");

	a_emit_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == erma_pkg::ST_EMIT && out_free) |=> out_valid_q)
		else $error("result not presented after emit");

endmodule

FILE: test/echo_average_checker.sv
// ----------------------------------------------------------------------------
// echo_average_checker
// Watches the echo range moving average block and checks every result word.
// ----------------------------------------------------------------------------
// Keeps its own copy of the thresholds, the distance ring and the report
// state. Each accepted echo word is turned into an expected reading and
// queued. Each accepted result word is compared field by field with the
// oldest queued reading. Register reads are checked against the copy.
// ----------------------------------------------------------------------------
module echo_average_checker #(
	parameter int DEPTH = erma_pkg::WINDOW_DEPTH_DEFAULT
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [erma_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [erma_pkg::APB_DATA_W-1:0] pwdata,
	input  logic [erma_pkg::APB_DATA_W-1:0] prdata,
	input  logic                            pready,
	input  logic                            in_valid,
	input  logic                            in_stall,
	input  logic [erma_pkg::ECHO_W-1:0]     echo_us,
	input  logic                            out_valid,
	input  logic                            out_stall,
	input  logic                            reading_valid,
	input  logic [erma_pkg::DIST_W-1:0]     avg_distance_q8,
	input  logic                            near_on,
	input  logic                            report,
	output int                              fail_count,
	output int                              pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned SPEED_Q16  = 1124;
	localparam int unsigned TIMEOUT_US = 30000;

	typedef struct packed {
		logic                        reading_valid;
		logic [erma_pkg::DIST_W-1:0] avg_distance_q8;
		logic                        near_on;
		logic                        report;
	} reading_t;

	reading_t                    expected_readings[$];
	logic [erma_pkg::DIST_W-1:0] max_range;
	logic [erma_pkg::DIST_W-1:0] near_limit;
	logic [erma_pkg::DIST_W-1:0] ring [DEPTH];
	int unsigned                 next_slot;
	logic                        ring_full;
	logic                        prev_near;
	logic                        first_due;
	int                          n_fail;

	function automatic reading_t predict_reading(input logic [erma_pkg::ECHO_W-1:0] echo);
		logic [25:0] product;
		logic [17:0] distance;
		logic        accepted;
		int unsigned total;
		int unsigned fill;
		int          i;
		reading_t    r;
		product  = 26'(echo) * 26'(SPEED_Q16);
		distance = product[25:8];
		accepted = (echo != '0) && (32'(echo) <= TIMEOUT_US)
			&& (distance <= 18'(max_range));
		r        = '0;
		if (accepted) begin
			if (next_slot >= DEPTH)
				next_slot = 0;
			ring[next_slot] = distance[erma_pkg::DIST_W-1:0];
			next_slot++;
			if (next_slot >= DEPTH) begin
				next_slot = 0;
				ring_full = 1'b1;
			end
			fill = ring_full ? DEPTH : next_slot;
			if (fill == 0)
				fill = 1;
			total = 0;
			for (i = 0; i < int'(fill); i++)
				total += ring[i];
			r.avg_distance_q8 = erma_pkg::DIST_W'(total / fill);
		end
		r.reading_valid = accepted;
		r.near_on       = accepted && (r.avg_distance_q8 < near_limit);
		r.report        = first_due || (r.near_on != prev_near);
		prev_near       = r.near_on;
		first_due       = 1'b0;
		return r;
	endfunction

	task automatic check_field(input string name, input longint unsigned want,
			input longint unsigned got);
		if (want != got) begin
			$display("%0t mismatch %s: expected %0d actual %0d", $time, name, want, got);
			n_fail++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		reading_t want;
		if (!arst_n) begin
			expected_readings.delete();
			max_range  = erma_pkg::MAX_RANGE_RESET;
			near_limit = erma_pkg::NEAR_LIMIT_RESET;
			for (int k = 0; k < DEPTH; k++)
				ring[k] = '0;
			next_slot  = 0;
			ring_full  = 1'b0;
			prev_near  = 1'b0;
			first_due  = 1'b1;
			n_fail     = 0;
			fail_count <= 0;
			pending    <= 0;
		end else begin
			if (psel && penable && pready) begin
				if (pwrite) begin
					if (paddr[2] == erma_pkg::REG_MAX_RANGE)
						max_range = pwdata[erma_pkg::DIST_W-1:0];
					else
						near_limit = pwdata[erma_pkg::DIST_W-1:0];
				end else if (paddr[2] == erma_pkg::REG_MAX_RANGE) begin
					check_field("prdata max_range", {16'b0, max_range}, prdata);
				end else begin
					check_field("prdata near_limit", {16'b0, near_limit}, prdata);
				end
			end
			if (out_valid && !out_stall) begin
				if (expected_readings.size() == 0) begin
					$display("%0t unexpected result word: expected none actual %0d/%0d/%0d/%0d",
						$time, reading_valid, avg_distance_q8, near_on, report);
					n_fail++;
				end else begin
					want = expected_readings.pop_front();
					check_field("reading_valid", want.reading_valid, reading_valid);
					check_field("avg_distance_q8", want.avg_distance_q8, avg_distance_q8);
					check_field("near_on", want.near_on, near_on);
					check_field("report", want.report, report);
				end
			end
			if (in_valid && !in_stall)
				expected_readings.push_back(predict_reading(echo_us));
			fail_count <= n_fail;
			pending    <= expected_readings.size();
		end
	end

endmodule

FILE: test/echo_range_moving_average_tb.sv
// ----------------------------------------------------------------------------
// echo_range_moving_average_tb
// Stimulus and verdict for the echo range moving average block.
// ----------------------------------------------------------------------------
// Drives echo words in bursts against a receiver that stalls on its own
// pattern, rewrites the two thresholds between phases while the block is
// idle, and leaves all checking to the checker instance beside the block.
// ----------------------------------------------------------------------------
module echo_range_moving_average_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH            = erma_pkg::WINDOW_DEPTH_DEFAULT;
	localparam int CYCLE_LIMIT      = 1000000;
	// Extra wait after draining, long enough to cover the tail of the last reading.
	localparam int SETTLE_CYCLES    = 20;
	localparam int LONG_HOLD_CYCLES = 300;
	localparam int RANDOM_PHASES    = 8;
	localparam int WORDS_PER_PHASE  = 227;

	logic                            clk;
	logic                            arst_n;
	logic                            psel;
	logic                            penable;
	logic                            pwrite;
	logic [erma_pkg::APB_ADDR_W-1:0] paddr;
	logic [erma_pkg::APB_DATA_W-1:0] pwdata;
	logic [erma_pkg::APB_DATA_W-1:0] prdata;
	logic                            pready;
	logic                            in_valid;
	logic                            in_stall;
	logic [erma_pkg::ECHO_W-1:0]     echo_us;
	logic                            out_valid;
	logic                            out_stall;
	logic                            reading_valid;
	logic [erma_pkg::DIST_W-1:0]     avg_distance_q8;
	logic                            near_on;
	logic                            report;

	int                              fail_count;
	int                              pending;
	int                              cycles;
	// Set by the stimulus, cleared by the receiver once its long hold is over.
	bit                              hold_req;
	// Chooses whether valid readings come from the near or the far end.
	bit                              low_run;
	logic [erma_pkg::DIST_W-1:0]     cur_max_range;

	echo_range_moving_average #(
		.WINDOW_DEPTH(DEPTH)
	) u_top (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_stall(in_stall), .echo_us(echo_us),
		.out_valid(out_valid), .out_stall(out_stall),
		.reading_valid(reading_valid), .avg_distance_q8(avg_distance_q8),
		.near_on(near_on), .report(report)
	);

	echo_average_checker #(
		.DEPTH(DEPTH)
	) u_checker (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_stall(in_stall), .echo_us(echo_us),
		.out_valid(out_valid), .out_stall(out_stall),
		.reading_valid(reading_valid), .avg_distance_q8(avg_distance_q8),
		.near_on(near_on), .report(report),
		.fail_count(fail_count), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Guard against a hung handshake; the slowest correct run is far below this.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("FAIL echo_range_moving_average");
			$finish;
		end
	end

	// Offer one echo word and hold it until the block takes it. The caller is
	// at a rising edge, so valid and payload change only there.
	task automatic send_word(input logic [erma_pkg::ECHO_W-1:0] width);
		in_valid <= 1'b1;
		echo_us  <= width;
		do @(posedge clk); while (in_stall);
	endtask

	// Stop sending and wait until every expected result word has been taken,
	// then allow the pipeline to settle before any register is touched. The
	// first edge makes sure a word accepted just now is already counted.
	task automatic drain;
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// One APB transfer: a setup cycle, an access cycle, then an idle cycle so
	// that back-to-back transfers never assign psel twice in one step.
	task automatic apb_transfer(input logic write, input logic idx,
			input logic [erma_pkg::DIST_W-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= write;
		paddr   <= {idx, 2'b00};
		pwdata  <= {16'($urandom), value};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// Write both thresholds and read them back; the checker compares the reads.
	task automatic apply_thresholds(input logic [erma_pkg::DIST_W-1:0] max_range,
			input logic [erma_pkg::DIST_W-1:0] near_limit);
		apb_transfer(1'b1, erma_pkg::REG_MAX_RANGE, max_range);
		apb_transfer(1'b1, erma_pkg::REG_NEAR_LIMIT, near_limit);
		apb_transfer(1'b0, erma_pkg::REG_MAX_RANGE, '0);
		apb_transfer(1'b0, erma_pkg::REG_NEAR_LIMIT, '0);
		cur_max_range = max_range;
	endtask

	// Mostly widths that land inside the accepted range, clustered at one end
	// or the other so that the average crosses the near limit now and then,
	// mixed with timeouts, widths past the timeout, full-range noise and the
	// range boundary itself.
	function automatic logic [erma_pkg::ECHO_W-1:0] draw_echo_width(
			input logic [erma_pkg::DIST_W-1:0] max_range);
		int unsigned lim;
		int unsigned pick;
		lim  = (32'(max_range) * 256 + 255) / 1124;
		if (lim > 30000)
			lim = 30000;
		pick = $urandom_range(0, 99);
		if (pick < 6)
			return '0;
		if (pick < 10)
			return erma_pkg::ECHO_W'($urandom_range(30001, 32767));
		if (pick < 16 || lim == 0)
			return erma_pkg::ECHO_W'($urandom_range(0, 32767));
		if (pick < 22)
			return erma_pkg::ECHO_W'(lim + $urandom_range(0, 1));
		if (low_run)
			return erma_pkg::ECHO_W'($urandom_range(1, (lim / 3 > 0) ? lim / 3 : 1));
		return erma_pkg::ECHO_W'($urandom_range((2 * lim / 3 > 0) ? 2 * lim / 3 : 1, lim));
	endfunction

	// Receiver: segments of no stall, light stall and heavy stall, and a long
	// hold whenever the stimulus asks for one. The hold is counted here so the
	// sender carries on offering words and the block backs up onto its input.
	initial begin
		int seg_len;
		int mode;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			seg_len = $urandom_range(1, 64);
			mode    = $urandom_range(0, 2);
			repeat (seg_len) begin
				if (hold_req) begin
					out_stall <= 1'b1;
					repeat (LONG_HOLD_CYCLES) @(posedge clk);
					hold_req = 1'b0;
				end
				case (mode)
					0: out_stall <= 1'b0;
					1: out_stall <= ($urandom_range(0, 3) == 0);
					default: out_stall <= ($urandom_range(0, 3) != 0);
				endcase
				@(posedge clk);
			end
		end
	end

	initial begin
		logic [erma_pkg::ECHO_W-1:0] opening_widths [21] = '{
			15'd0, 15'd1, 15'd2332, 15'd2333, 15'd30000, 15'd30001, 15'd32767,
			15'd16384, 15'd1, 15'd1, 15'd1, 15'd1, 15'd1, 15'd0,
			15'd2332, 15'd2332, 15'd2332, 15'd2332, 15'd2332, 15'd1165, 15'd0
		};
		logic [erma_pkg::ECHO_W-1:0] wide_widths  [6] = '{15'd14926, 15'd14927,
			15'd30000, 15'd1, 15'd0, 15'd14926};
		logic [erma_pkg::ECHO_W-1:0] closed_widths[4] = '{15'd1, 15'd0, 15'd30000,
			15'd32767};
		logic [erma_pkg::ECHO_W-1:0] never_widths [3] = '{15'd1, 15'd14926, 15'd100};
		logic [erma_pkg::DIST_W-1:0] max_range;
		logic [erma_pkg::DIST_W-1:0] near_limit;
		int                          sent;
		int                          burst_len;
		int                          gap;

		// Every input known from time zero, reset asserted straight away.
		arst_n    = 1'b0;
		psel      = 1'b0;
		penable   = 1'b0;
		pwrite    = 1'b0;
		paddr     = '0;
		pwdata    = '0;
		in_valid  = 1'b0;
		echo_us   = '0;
		out_stall = 1'b0;
		cycles    = 0;
		hold_req  = 1'b0;
		low_run   = 1'b0;
		cur_max_range = erma_pkg::MAX_RANGE_RESET;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset thresholds: timeout first, the range boundary either side,
		// widths past the timeout, a full ring that wraps, and an invalid
		// reading straight after a near one.
		foreach (opening_widths[i])
			send_word(opening_widths[i]);
		drain();

		// Widest range and highest near limit.
		apply_thresholds(16'hFFFF, 16'hFFFF);
		foreach (wide_widths[i])
			send_word(wide_widths[i]);
		drain();

		// Zero range: nothing can be accepted.
		apply_thresholds(16'h0000, 16'h0000);
		foreach (closed_widths[i])
			send_word(closed_widths[i]);
		drain();

		// Zero near limit: the indicator can never come on.
		apply_thresholds(16'hFFFF, 16'h0000);
		foreach (never_widths[i])
			send_word(never_widths[i]);
		drain();

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			case (ph)
				0: begin
					max_range  = erma_pkg::MAX_RANGE_RESET;
					near_limit = erma_pkg::NEAR_LIMIT_RESET;
				end
				1: begin
					max_range  = 16'hFFFF;
					near_limit = 16'h8000;
				end
				2: begin
					max_range  = 16'd1024;
					near_limit = 16'hFFFF;
				end
				default: begin
					max_range  = erma_pkg::DIST_W'($urandom_range(0, 65535));
					near_limit = erma_pkg::DIST_W'($urandom_range(0, max_range));
				end
			endcase
			apply_thresholds(max_range, near_limit);
			// The receiver sits on its output while words keep coming.
			if (ph == 1)
				hold_req = 1'b1;
			sent = 0;
			while (sent < WORDS_PER_PHASE) begin
				burst_len = $urandom_range(1, 24);
				if ($urandom_range(0, 2) == 0)
					low_run = ~low_run;
				repeat (burst_len) begin
					send_word(draw_echo_width(cur_max_range));
					sent++;
				end
				// Halfway through one phase the sender waits for every result.
				if (ph == 3 && sent >= WORDS_PER_PHASE / 2 &&
						sent - burst_len < WORDS_PER_PHASE / 2) begin
					in_valid <= 1'b0;
					do @(posedge clk); while (pending != 0);
				end else begin
					gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
					if (gap != 0) begin
						in_valid <= 1'b0;
						echo_us  <= erma_pkg::ECHO_W'($urandom);
						repeat (gap) @(posedge clk);
					end
				end
			end
			drain();
		end

		if (fail_count == 0 && pending == 0) begin
			$display("PASS echo_range_moving_average");
		end else begin
			$display("FAIL echo_range_moving_average");
		end
		$finish;
	end

endmodule
